// ----- rtl/itdr_pkg.sv -----
// Package: widths, display codes and the work record of the digit pipeline.
`timescale 1ns / 1ps

package itdr_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int NUM_W       = 32;
  localparam int UPPER_W     = 27;
  localparam int LOWER_W     = 25;
  localparam int CFG_DATA_W  = 27;
  localparam int MAG_W       = 27;
  localparam int CODE_W      = 4;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 8;
  localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);

  localparam logic [UPPER_W-1:0] UPPER_RESET = UPPER_W'(99999999);
  localparam logic [LOWER_W-1:0] LOWER_RESET = LOWER_W'(-9999999);

  // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for any x below 2^32
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [CODE_W-1:0] CODE_MINUS  = 4'hA;
  localparam logic [CODE_W-1:0] CODE_BLANK  = 4'hF;
  localparam logic [ADDR_W-1:0] ADDR_DECODE = 4'd9;
  localparam logic [DATA_W-1:0] DATA_DECODE = 8'hFF;

  typedef enum logic [0:0] {
    CFG_UPPER = 1'b0,
    CFG_LOWER = 1'b1
  } cfg_idx_e;

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t [DIGIT_COUNT-1:0] codes_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             started;
    logic             sign_done;
    logic             oob;
    codes_t           codes;
  } dig_work_t;

endpackage

// ----- rtl/itdr_if.sv -----
// Handshake interfaces: number items in, register write items out.
`timescale 1ns / 1ps

interface itdr_num_if;
  logic                        valid;
  logic                        ready;
  logic [itdr_pkg::NUM_W-1:0]  number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface itdr_wr_if;
  logic                        valid;
  logic                        ready;
  logic [itdr_pkg::ADDR_W-1:0] reg_addr;
  logic [itdr_pkg::DATA_W-1:0] reg_data;
  logic                        last_write;

  modport source (output valid, output reg_addr, output reg_data, output last_write,
                  input ready);
  modport sink   (input valid, input reg_addr, input reg_data, input last_write,
                  output ready);
endinterface

// ----- rtl/itdr_digit_stage.sv -----
// One pipeline stage: peels off the lowest decimal digit and shifts its code in.
`timescale 1ns / 1ps

module itdr_digit_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  itdr_pkg::dig_work_t work_i,
  output logic                valid_o,
  input  logic                ready_i,
  output itdr_pkg::dig_work_t work_o
);
  import itdr_pkg::*;

  logic                              valid_q;
  dig_work_t                         work_q, work_d;
  logic [MAG_W+32-1:0]               prod;
  logic [MAG_W-1:0]                  quot;
  logic [MAG_W-1:0]                  quot_x10;
  code_t                             rem;
  code_t                             code;

  always_comb begin
    prod     = (MAG_W + 32)'(work_i.mag) * (MAG_W + 32)'(RECIP_10);
    quot     = MAG_W'(prod >> RECIP_SHIFT);
    quot_x10 = MAG_W'({quot, 3'b000}) + MAG_W'({quot, 1'b0});
    rem      = CODE_W'(work_i.mag - quot_x10);
  end

  always_comb begin
    work_d         = work_i;
    work_d.mag     = quot;
    work_d.started = 1'b1;
    if (work_i.mag != '0 || !work_i.started) begin
      code = rem;
    end else if (work_i.neg && !work_i.sign_done) begin
      code             = CODE_MINUS;
      work_d.sign_done = 1'b1;
    end else begin
      code = CODE_BLANK;
    end
    work_d.codes = {code, work_i.codes[DIGIT_COUNT-1:1]};
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign work_o  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

endmodule

// ----- rtl/int_to_digit_register_writes_core.sv -----
// Top level: signed integer to the nine register writes of a code-B digit display.
//
// Each number item gives nine write items: decode mode (address 9, data 0xFF), then digit
// registers 8 down to 1 holding the right-justified decimal form (0xA minus, 0xF blank).
// A number outside [lower_limit, upper_limit], or one too wide for eight positions, shows
// minus in every position. A number passes an input register, a bounds/magnitude stage and
// eight divide-by-ten stages (one digit each) before the write sequencer, which issues one
// write per cycle while wr_out.ready is high and takes the next number only once the last
// write of a sequence is taken; the pipeline buffers up to ten further numbers while a
// sequence is being drained. Limits must be written only while idle; the block does not enforce this.
`timescale 1ns / 1ps

module int_to_digit_register_writes_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  itdr_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [itdr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  itdr_num_if.sink                         num_in,
  itdr_wr_if.source                        wr_out
);
  import itdr_pkg::*;

  logic [UPPER_W-1:0] upper_q;
  logic [LOWER_W-1:0] lower_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RESET;
      lower_q <= LOWER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UPPER: upper_q <= cfg_data_i[UPPER_W-1:0];
        CFG_LOWER: lower_q <= cfg_data_i[LOWER_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  logic [NUM_W-1:0] number_q;
  logic             front_ready;

  assign num_in.ready = !in_valid_q || front_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (num_in.ready) begin
      in_valid_q <= num_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (num_in.valid && num_in.ready) begin
      number_q <= num_in.number;
    end
  end

  // bounds check and magnitude
  logic [NUM_W:0]   num_ext, hi_ext, lo_ext;
  logic [NUM_W-1:0] abs_val;
  dig_work_t        front_d;

  logic [DIGIT_COUNT:0] wv;
  logic [DIGIT_COUNT:0] wr;
  dig_work_t            wd [DIGIT_COUNT+1];

  always_comb begin
    num_ext = {number_q[NUM_W-1], number_q};
    hi_ext  = (NUM_W + 1)'(upper_q);
    lo_ext  = {{(NUM_W + 1 - LOWER_W){lower_q[LOWER_W-1]}}, lower_q};
    abs_val = number_q[NUM_W-1] ? (NUM_W)'(-number_q) : number_q;
    front_d.mag       = abs_val[MAG_W-1:0];
    front_d.neg       = number_q[NUM_W-1];
    front_d.started   = 1'b0;
    front_d.sign_done = 1'b0;
    front_d.oob       = ($signed(num_ext) > $signed(hi_ext)) ||
                        ($signed(num_ext) < $signed(lo_ext));
    front_d.codes     = '0;
  end

  logic front_valid_q;

  assign front_ready = !front_valid_q || wr[0];
  assign wv[0]       = front_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (front_ready) begin
      front_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && front_ready) begin
      wd[0] <= front_d;
    end
  end

  // digit stages, position 1 first
  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_dig
    itdr_digit_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (wv[g]),
      .ready_o (wr[g]),
      .work_i  (wd[g]),
      .valid_o (wv[g+1]),
      .ready_i (wr[g+1]),
      .work_o  (wd[g+1])
    );
  end

  // write sequencer
  logic             seq_valid_q;
  logic [CNT_W-1:0] cnt_q;
  codes_t           codes_q;
  logic             seq_last;
  logic             seq_take;
  logic             all_minus;

  assign seq_last  = (cnt_q == CNT_W'(DIGIT_COUNT));
  assign seq_take  = seq_valid_q && wr_out.ready;
  assign wr[DIGIT_COUNT] = !seq_valid_q || (seq_take && seq_last);
  assign all_minus = wd[DIGIT_COUNT].oob || (wd[DIGIT_COUNT].mag != '0) ||
                     (wd[DIGIT_COUNT].neg && !wd[DIGIT_COUNT].sign_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (wr[DIGIT_COUNT]) begin
      seq_valid_q <= wv[DIGIT_COUNT];
      cnt_q       <= '0;
    end else if (seq_take) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr[DIGIT_COUNT] && wv[DIGIT_COUNT]) begin
      codes_q <= all_minus ? {DIGIT_COUNT{CODE_MINUS}} : wd[DIGIT_COUNT].codes;
    end else if (seq_take && cnt_q != '0) begin
      codes_q <= {codes_q[DIGIT_COUNT-2:0], CODE_BLANK};
    end
  end

  assign wr_out.valid      = seq_valid_q;
  assign wr_out.reg_addr   = (cnt_q == '0) ? ADDR_DECODE
                                           : ADDR_W'(DIGIT_COUNT + 1 - int'(cnt_q));
  assign wr_out.reg_data   = (cnt_q == '0) ? DATA_DECODE
                                           : DATA_W'(codes_q[DIGIT_COUNT-1]);
  assign wr_out.last_write = seq_last;

  a_last_is_digit1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_q && seq_last |-> wr_out.reg_addr == ADDR_W'(1))
    else $error("last write not to digit 1");

  a_decode_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_q && cnt_q == '0 |-> wr_out.reg_data == DATA_DECODE)
    else $error("decode write with wrong data");

  a_seq_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_take && !seq_last |=> seq_valid_q && cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("write sequence broken off");

  a_digit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_valid_q && cnt_q != '0 |->
      codes_q[DIGIT_COUNT-1] <= CODE_W'(9) || codes_q[DIGIT_COUNT-1] == CODE_MINUS ||
      codes_q[DIGIT_COUNT-1] == CODE_BLANK)
    else $error("invalid digit code");

endmodule

// ----- tb/sv/tb_int_to_digit_register_writes_core.sv -----
// Testbench: integer to display register writes, checked against a local digit predictor.
`timescale 1ns / 1ps

module tb_int_to_digit_register_writes_core;
  import itdr_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } disp_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  itdr_num_if num_ch ();
  itdr_wr_if  wr_ch ();

  int_to_digit_register_writes_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .num_in     (num_ch),
    .wr_out     (wr_ch)
  );

  disp_write_t        pending_writes[$];
  disp_write_t        got_w;
  disp_write_t        exp_w;
  logic [UPPER_W-1:0] upper_lim;
  logic [LOWER_W-1:0] lower_lim;
  int                 errors = 0;
  int                 idle_pct;
  int                 stall_pct;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    wr_ch.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && wr_ch.valid && wr_ch.ready) begin
      got_w = '{wr_ch.reg_addr, wr_ch.reg_data, wr_ch.last_write};
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write addr %h data %h last %b", $time,
                 got_w.addr, got_w.data, got_w.last);
        errors++;
      end else begin
        exp_w = pending_writes.pop_front();
        if (got_w !== exp_w) begin
          $display("%0t: expected addr %h data %h last %b, got addr %h data %h last %b",
                   $time, exp_w.addr, exp_w.data, exp_w.last,
                   got_w.addr, got_w.data, got_w.last);
          errors++;
        end
      end
    end
  end

  function automatic longint pow10(int d);
    longint r;
    r = 1;
    for (int i = 0; i < d; i++) r = r * 10;
    return r;
  endfunction

  // nine writes: decode mode, then digit 8 down to digit 1
  function automatic void predict_digit_writes(logic [NUM_W-1:0] n);
    longint v;
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    bit     neg;
    bit     show;
    code_t  codes[DIGIT_COUNT];
    v = $signed(n);
    lo = $signed(lower_lim);
    hi = longint'(upper_lim);
    show = (v <= hi) && (v >= lo);
    neg = v < 0;
    mag = neg ? -v : v;
    ndig = 0;
    do begin
      ndig++;
      mag = mag / 10;
    end while (mag != 0);
    if (ndig + int'(neg) > DIGIT_COUNT) show = 0;
    mag = neg ? -v : v;
    for (int p = 0; p < DIGIT_COUNT; p++) begin
      if (!show) begin
        codes[p] = CODE_MINUS;
      end else if (p < ndig) begin
        codes[p] = code_t'(mag % 10);
        mag = mag / 10;
      end else if (p == ndig && neg) begin
        codes[p] = CODE_MINUS;
      end else begin
        codes[p] = CODE_BLANK;
      end
    end
    pending_writes.push_back('{ADDR_DECODE, DATA_DECODE, 1'b0});
    for (int a = DIGIT_COUNT; a >= 1; a--) begin
      pending_writes.push_back('{ADDR_W'(a), DATA_W'(codes[a-1]), a == 1});
    end
  endfunction

  task automatic send_number(input logic [NUM_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      num_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    num_ch.valid  <= 1'b1;
    num_ch.number <= n;
    do @(posedge clk_i); while (!num_ch.ready);
    predict_digit_writes(n);
  endtask

  task automatic wait_idle();
    num_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_limits(input longint up, input longint lo);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_UPPER;
    cfg_data_i <= up[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LOWER;
    cfg_data_i <= lo[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    upper_lim = up[UPPER_W-1:0];
    lower_lim = lo[LOWER_W-1:0];
  endtask

  function automatic logic [NUM_W-1:0] rand_number();
    longint v;
    longint mlo;
    int     d;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        d = $urandom_range(1, DIGIT_COUNT);
        mlo = (d == 1) ? 0 : pow10(d - 1);
        v = mlo + $urandom_range(int'(pow10(d) - 1 - mlo));
        if ($urandom_range(1) && d < DIGIT_COUNT) v = -v;
      end
      5: v = longint'(upper_lim) + $urandom_range(2) - 1;
      6: v = longint'($signed(lower_lim)) + $urandom_range(2) - 1;
      default: v = longint'($urandom);
    endcase
    return v[NUM_W-1:0];
  endfunction

  task automatic test_reset_limits();
    longint vals[$];
    vals = '{0, 1, -1, 9, 10, -10, 12345678, -1234567, 99999999, 100000000,
             -9999999, -10000000, 2147483647, -2147483648, 32'h5555_5555};
    foreach (vals[i]) send_number(vals[i][NUM_W-1:0]);
  endtask

  // limits past their stated ranges: nine characters must give all minus
  task automatic test_wide_limits();
    longint vals[$];
    set_limits((1 << UPPER_W) - 1, -(1 << (LOWER_W - 1)));
    vals = '{134217727, 100000000, 99999999, -16777216, -10000000, -9999999};
    foreach (vals[i]) send_number(vals[i][NUM_W-1:0]);
  endtask

  task automatic test_tight_and_crossed_limits();
    set_limits(0, 0);
    send_number(0);
    send_number(1);
    send_number(-1);
    set_limits(50, 100);
    send_number(75);
    send_number(0);
  endtask

  task automatic test_random_phases();
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 45, 0, 20};
    stall_set = '{0, 0, 45, 20};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_limits(99999999, -9999999);
        2: set_limits((1 << UPPER_W) - 1, -(1 << (LOWER_W - 1)));
        default: set_limits($urandom_range(99999999), -longint'($urandom_range(9999999)));
      endcase
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int i = 0; i < 26; i++) send_number(rand_number());
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_UPPER;
    cfg_data_i    = '0;
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    upper_lim     = UPPER_RESET;
    lower_lim     = LOWER_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_limits();
    test_wide_limits();
    test_tight_and_crossed_limits();
    test_random_phases();
    wait_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
